/* hdl/glpm_pkg.sv */
// shared constants for the grid line point membership block
package glpm_pkg;

    localparam int COORD_BITS_DEF = 8;

endpackage

/* hdl/glpm_mul.sv */
// registered-product multiplier shared by the sequencer for k*l, a*(l+1), b*(k+1)
module glpm_mul #(
    parameter int COORD_BITS = glpm_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic [COORD_BITS-1:0]     i_a,
    input  logic [COORD_BITS:0]       i_b,
    output logic [2*COORD_BITS-1:0]   o_p
);

    localparam int FW = 2 * COORD_BITS + 1;

    logic [FW-1:0] full_p;
    logic [2*COORD_BITS-1:0] r_p;

    // operands never push the product past 2*COORD_BITS bits
    assign full_p = FW'(i_a) * FW'(i_b);

    always_ff @(posedge i_clk) begin
        r_p <= full_p[2*COORD_BITS-1:0];
    end

    assign o_p = r_p;

endmodule

/* hdl/grid_line_point_membership.sv */
// top level: sequencer that decides if a point lies on the walked grid line
// result: o_valid rises straight out of S_PREP when the answer follows from
//   the end points or the axis ranges, otherwise out of S_DEC after S_MT, S_MA, S_MB
// a new beat is taken only in S_IDLE; busy is high from accept until the result
//   cycle, and the one multiplier serves k*l, a*(l+1) and b*(k+1) in turn
// the receiver cannot stall: o_valid stands for exactly one cycle
// reset: synchronous active-low i_rst_n returns the sequencer to idle and clears o_valid
module grid_line_point_membership #(
    parameter int COORD_BITS = glpm_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [COORD_BITS-1:0] i_query_x,
    input  logic [COORD_BITS-1:0] i_query_y,
    output logic                  o_valid,
    output logic                  o_on_line
);

    localparam int W  = COORD_BITS;
    localparam int PW = 2 * COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MT,
        S_MA,
        S_MB,
        S_DEC
    } t_state;

    t_state r_state;
    logic   r_valid;
    logic   r_on_line;

    logic [W-1:0]  r_sx, r_sy, r_ex, r_ey, r_qx, r_qy;
    logic [W-1:0]  r_k, r_l, r_a, r_b;
    logic [PW-1:0] r_lo, r_hi;

    logic          hit_end, degen, x_fwd, y_fwd, x_ok, y_ok;
    logic [W-1:0]  k_c, l_c, a_c, b_c, kl_max;
    logic [W-1:0]  mul_a;
    logic [W:0]    mul_b;
    logic [PW-1:0] prod;
    logic [PW-1:0] ma_hi;
    logic [PW-1:0] mb_ea, mb_lo, mb_hi;
    logic [PW-1:0] dec_eb, dec_lo, dec_hi;

    // end point and per-axis range checks, spans and offsets on the captured beat
    always_comb begin
        hit_end = (r_qx == r_sx && r_qy == r_sy) || (r_qx == r_ex && r_qy == r_ey);
        degen   = (r_sx == r_ex) && (r_sy == r_ey);
        k_c     = (r_ex >= r_sx) ? r_ex - r_sx : r_sx - r_ex;
        l_c     = (r_ey >= r_sy) ? r_ey - r_sy : r_sy - r_ey;
        x_fwd   = r_ex > r_sx;
        y_fwd   = r_ey > r_sy;
        a_c     = x_fwd ? r_qx - r_sx : r_sx - r_qx;
        b_c     = y_fwd ? r_qy - r_sy : r_sy - r_qy;
        if (k_c == '0) begin
            x_ok = r_qx == r_sx;
        end else if (x_fwd) begin
            x_ok = (r_qx >= r_sx) && (r_qx <= r_ex);
        end else begin
            x_ok = (r_qx <= r_sx) && (r_qx >= r_ex);
        end
        if (l_c == '0) begin
            y_ok = r_qy == r_sy;
        end else if (y_fwd) begin
            y_ok = (r_qy >= r_sy) && (r_qy <= r_ey);
        end else begin
            y_ok = (r_qy <= r_sy) && (r_qy >= r_ey);
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_MA: begin
                mul_a = r_a;
                mul_b = {1'b0, r_l} + (W+1)'(1);
            end
            S_MB: begin
                mul_a = r_b;
                mul_b = {1'b0, r_k} + (W+1)'(1);
            end
            default: begin
                mul_a = r_k;
                mul_b = {1'b0, r_l};
            end
        endcase
    end

    glpm_mul #(
        .COORD_BITS(COORD_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // window of walk iterations in which the query can be reached
    always_comb begin
        kl_max = (r_k > r_l) ? r_k : r_l;
        ma_hi  = prod + PW'(kl_max) - PW'(1);
        mb_ea  = prod + PW'(r_l);
        mb_lo  = r_lo;
        mb_hi  = r_hi;
        if (r_k != '0) begin
            if (prod > r_lo) begin
                mb_lo = prod;
            end
            if (mb_ea < r_hi) begin
                mb_hi = mb_ea;
            end
        end
        dec_eb = prod + PW'(r_k);
        dec_lo = r_lo;
        dec_hi = r_hi;
        if (r_l != '0) begin
            if (prod > r_lo) begin
                dec_lo = prod;
            end
            if (dec_eb < r_hi) begin
                dec_hi = dec_eb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_on_line <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_valid <= 1'b0;
                    if (start) begin
                        r_sx    <= i_start_x;
                        r_sy    <= i_start_y;
                        r_ex    <= i_end_x;
                        r_ey    <= i_end_y;
                        r_qx    <= i_query_x;
                        r_qy    <= i_query_y;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_k <= k_c;
                    r_l <= l_c;
                    r_a <= a_c;
                    r_b <= b_c;
                    if (hit_end) begin
                        r_valid   <= 1'b1;
                        r_on_line <= 1'b1;
                        r_state   <= S_IDLE;
                    end else if (degen || !x_ok || !y_ok) begin
                        r_valid   <= 1'b1;
                        r_on_line <= 1'b0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_valid <= 1'b0;
                        r_state <= S_MT;
                    end
                end
                S_MT: begin
                    r_valid <= 1'b0;
                    r_state <= S_MA;
                end
                S_MA: begin
                    // prod holds k*l here
                    r_valid <= 1'b0;
                    r_lo    <= PW'(1);
                    r_hi    <= ma_hi;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_valid <= 1'b0;
                    r_lo    <= mb_lo;
                    r_hi    <= mb_hi;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_valid   <= 1'b1;
                    r_on_line <= dec_lo <= dec_hi;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = r_state != S_IDLE;
    assign o_valid   = r_valid;
    assign o_on_line = r_on_line;

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while sequencer still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without preceding work");

    a_end_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP && hit_end) |=> (o_valid && o_on_line))
        else $error("end point query not reported on the line");

endmodule

/* tb/grid_line_point_membership_tb.sv */
// testbench for grid_line_point_membership: closed-form line walk prediction, bursty commands
module grid_line_point_membership_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = glpm_pkg::COORD_BITS_DEF;
    localparam int MAXC         = (1 << CW) - 1;
    localparam int RANDOM_BEATS = 400;
    localparam int DRAIN_EVERY  = 97;
    localparam int IDLE_LIMIT   = 2000;

    typedef logic [CW-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        coord_t query_x;
        coord_t query_y;
    } probe_t;

    typedef struct packed {
        probe_t probe;
        logic   on_line;
    } answer_t;

    logic   i_clk     = 1'b0;
    logic   i_rst_n   = 1'b0;
    logic   start     = 1'b0;
    logic   busy;
    coord_t i_start_x = '0;
    coord_t i_start_y = '0;
    coord_t i_end_x   = '0;
    coord_t i_end_y   = '0;
    coord_t i_query_x = '0;
    coord_t i_query_y = '0;
    logic   o_valid;
    logic   o_on_line;

    probe_t  probe_q[$];
    answer_t answer_q[$];
    probe_t  cur_probe;
    int      total_beats  = 0;
    int      accepted_cnt = 0;
    int      fail_cnt     = 0;
    int      idle_cycles  = 0;
    int      burst_left   = 0;
    int      gap_left     = 0;
    bit      loaded       = 1'b0;
    bit      drain_hold   = 1'b0;

    grid_line_point_membership #(
        .COORD_BITS(CW)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_query_x (i_query_x),
        .i_query_y (i_query_y),
        .o_valid   (o_valid),
        .o_on_line (o_on_line)
    );

    always #5 i_clk = ~i_clk;

    // steps along one axis from p0 toward p1 to reach q, 0 if q lies outside the span
    function automatic bit axis_reach(input coord_t p0, input coord_t p1, input coord_t q,
                                      output int unsigned steps);
        steps = 0;
        if (p1 > p0) begin
            if (q < p0 || q > p1) return 1'b0;
            steps = q - p0;
        end else begin
            if (q > p0 || q < p1) return 1'b0;
            steps = p0 - q;
        end
        return 1'b1;
    endfunction

    // x has stepped a times during iterations [a*(dy+1), a*(dy+1)+dy], y likewise;
    // the query is visited if both windows overlap strictly inside the walk
    function automatic bit line_hit(input probe_t p);
        int unsigned dx, dy, span, lo, hi, a, b;
        if ((p.query_x == p.start_x && p.query_y == p.start_y) ||
            (p.query_x == p.end_x && p.query_y == p.end_y)) return 1'b1;
        if (p.start_x == p.end_x && p.start_y == p.end_y) return 1'b0;
        dx   = (p.end_x >= p.start_x) ? p.end_x - p.start_x : p.start_x - p.end_x;
        dy   = (p.end_y >= p.start_y) ? p.end_y - p.start_y : p.start_y - p.end_y;
        span = dx * dy + ((dx > dy) ? dx : dy);
        lo   = 1;
        hi   = span - 1;
        if (dx == 0) begin
            if (p.query_x != p.start_x) return 1'b0;
        end else begin
            if (!axis_reach(p.start_x, p.end_x, p.query_x, a)) return 1'b0;
            if (a * (dy + 1) > lo) lo = a * (dy + 1);
            if (a * (dy + 1) + dy < hi) hi = a * (dy + 1) + dy;
        end
        if (dy == 0) begin
            if (p.query_y != p.start_y) return 1'b0;
        end else begin
            if (!axis_reach(p.start_y, p.end_y, p.query_y, b)) return 1'b0;
            if (b * (dx + 1) > lo) lo = b * (dx + 1);
            if (b * (dx + 1) + dx < hi) hi = b * (dx + 1) + dx;
        end
        return lo <= hi;
    endfunction

    function automatic probe_t mk_probe(input int sx, input int sy, input int ex, input int ey,
                                        input int qx, input int qy);
        probe_t p;
        p.start_x = coord_t'(sx);
        p.start_y = coord_t'(sy);
        p.end_x   = coord_t'(ex);
        p.end_y   = coord_t'(ey);
        p.query_x = coord_t'(qx);
        p.query_y = coord_t'(qy);
        return p;
    endfunction

    function automatic coord_t nudge(input coord_t c, input int off);
        int v;
        v = int'(c) + off;
        if (v < 0) v = 0;
        if (v > MAXC) v = MAXC;
        return coord_t'(v);
    endfunction

    // a position the walk reaches after a random number of iterations
    function automatic void walk_point(input probe_t p, output coord_t wx, output coord_t wy);
        int unsigned dx, dy, span, t, ax, ay;
        dx   = (p.end_x >= p.start_x) ? p.end_x - p.start_x : p.start_x - p.end_x;
        dy   = (p.end_y >= p.start_y) ? p.end_y - p.start_y : p.start_y - p.end_y;
        span = dx * dy + ((dx > dy) ? dx : dy);
        t    = $urandom_range(0, span);
        ax   = t / (dy + 1);
        ay   = t / (dx + 1);
        if (ax > dx) ax = dx;
        if (ay > dy) ay = dy;
        wx = (p.end_x >= p.start_x) ? p.start_x + coord_t'(ax) : p.start_x - coord_t'(ax);
        wy = (p.end_y >= p.start_y) ? p.start_y + coord_t'(ay) : p.start_y - coord_t'(ay);
    endfunction

    function automatic probe_t random_probe();
        probe_t p;
        int     shape, pick;
        coord_t wx, wy;
        p.start_x = coord_t'($urandom_range(0, MAXC));
        p.start_y = coord_t'($urandom_range(0, MAXC));
        p.end_x   = coord_t'($urandom_range(0, MAXC));
        p.end_y   = coord_t'($urandom_range(0, MAXC));
        shape     = $urandom_range(0, 9);
        if (shape >= 4 && shape <= 7) begin
            p.end_x = nudge(p.start_x, $urandom_range(0, 16) - 8);
            p.end_y = nudge(p.start_y, $urandom_range(0, 16) - 8);
        end else if (shape == 8) begin
            if ($urandom_range(0, 1) == 0) p.end_y = p.start_y;
            else p.end_x = p.start_x;
        end else if (shape == 9) begin
            p.end_x = p.start_x;
            p.end_y = p.start_y;
        end
        walk_point(p, wx, wy);
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
            p.query_x = wx;
            p.query_y = wy;
        end else if (pick == 5) begin
            p.query_x = ($urandom_range(0, 1) == 0) ? p.start_x : p.end_x;
            p.query_y = ($urandom_range(0, 1) == 0) ? p.start_y : p.end_y;
        end else if (pick == 6) begin
            // one unit off a visited point: often just misses the line
            p.query_x = ($urandom_range(0, 1) == 0) ? wx : wx + coord_t'(1);
            p.query_y = ($urandom_range(0, 1) == 0) ? wy : wy - coord_t'(1);
        end else begin
            p.query_x = coord_t'($urandom_range(0, MAXC));
            p.query_y = coord_t'($urandom_range(0, MAXC));
        end
        return p;
    endfunction

    // driver: bursts of commands with random gaps, occasional full drain
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                answer_q.push_back('{probe: cur_probe, on_line: line_hit(cur_probe)});
                accepted_cnt++;
                if (accepted_cnt % DRAIN_EVERY == 0) drain_hold = 1'b1;
                loaded = 1'b0;
            end
            if (drain_hold && answer_q.size() == 0) drain_hold = 1'b0;
            if (!loaded && gap_left > 0) begin
                gap_left--;
            end else if (!loaded && !drain_hold && probe_q.size() > 0) begin
                cur_probe = probe_q.pop_front();
                i_start_x <= cur_probe.start_x;
                i_start_y <= cur_probe.start_y;
                i_end_x   <= cur_probe.end_x;
                i_end_y   <= cur_probe.end_y;
                i_query_x <= cur_probe.query_x;
                i_query_y <= cur_probe.query_y;
                start     <= 1'b1;
                loaded    = 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            if (!loaded) start <= 1'b0;
        end
    end

    // monitor: every strobed result is checked against the oldest pending answer
    always @(posedge i_clk) begin
        answer_t want;
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                $display("%0t ns: result beat with nothing pending: expected none actual %0b",
                         $time, o_on_line);
                fail_cnt++;
            end else begin
                want = answer_q.pop_front();
                if (o_on_line !== want.on_line) begin
                    $display("%0t ns: on_line for (%0d,%0d)->(%0d,%0d) q (%0d,%0d): exp %0b act %0b",
                             $time, want.probe.start_x, want.probe.start_y, want.probe.end_x,
                             want.probe.end_y, want.probe.query_x, want.probe.query_y,
                             want.on_line, o_on_line);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int n;
        // end points, degenerate lines, axis lines, full-span diagonals, out-of-span queries
        probe_q.push_back(mk_probe(0, 0, 0, 0, 0, 0));
        probe_q.push_back(mk_probe(5, 5, 5, 5, 5, 6));
        probe_q.push_back(mk_probe(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        probe_q.push_back(mk_probe(0, 0, MAXC, MAXC, 128, 128));
        probe_q.push_back(mk_probe(0, 0, MAXC, MAXC, 128, 127));
        probe_q.push_back(mk_probe(MAXC, 0, 0, MAXC, 0, 0));
        probe_q.push_back(mk_probe(0, MAXC, MAXC, 0, MAXC, MAXC));
        probe_q.push_back(mk_probe(0, MAXC, MAXC, 0, 128, 127));
        probe_q.push_back(mk_probe(0, 10, MAXC, 10, 100, 10));
        probe_q.push_back(mk_probe(0, 10, MAXC, 10, 100, 11));
        probe_q.push_back(mk_probe(7, MAXC, 7, 0, 7, 3));
        probe_q.push_back(mk_probe(7, MAXC, 7, 0, 8, 3));
        probe_q.push_back(mk_probe(200, 3, 10, 250, 10, 250));
        probe_q.push_back(mk_probe(200, 3, 10, 250, 200, 3));
        probe_q.push_back(mk_probe(10, 10, 20, 15, 9, 10));
        probe_q.push_back(mk_probe(10, 10, 20, 15, 21, 15));
        probe_q.push_back(mk_probe(10, 10, 20, 15, 15, 12));
        probe_q.push_back(mk_probe(0, 0, 1, MAXC, 0, 100));
        probe_q.push_back(mk_probe(0, 0, 1, MAXC, 1, 200));
        probe_q.push_back(mk_probe(0, 0, 1, MAXC, 1, 0));
        probe_q.push_back(mk_probe(MAXC, MAXC, 0, MAXC - 1, 128, MAXC));
        probe_q.push_back(mk_probe(MAXC, MAXC, 0, MAXC - 1, 128, MAXC - 1));
        probe_q.push_back(mk_probe('haa, 'h55, 'h55, 'haa, 'h80, 'h80));
        probe_q.push_back(mk_probe('h55, 'haa, 'haa, 'h55, 'h7f, 'h80));
        for (n = 0; n < RANDOM_BEATS; n++) probe_q.push_back(random_probe());
        total_beats = probe_q.size();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_cnt < total_beats || answer_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
